>>> hdl/assert_macros.svh
// assertion macros used by the checker file
// expects signals named clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CCT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define CCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hdl/cct_pkg.sv
// shared constants, types and register numbering of the compare/capture timer
// no dependencies
package cct_pkg;

	localparam int CHANNELS     = 4;
	localparam int PRESCALE_MAX = 9;

	// dense register numbering
	localparam int R_START   = 0;
	localparam int R_STOP    = 1;
	localparam int R_COUNT   = 2;
	localparam int R_CLEAR   = 3;
	localparam int R_CAPT    = 4;
	localparam int R_CMP     = R_CAPT + CHANNELS;
	localparam int R_SHORTS  = R_CAPT + 2 * CHANNELS;
	localparam int R_INTSET  = R_SHORTS + 1;
	localparam int R_INTCLR  = R_SHORTS + 2;
	localparam int R_MODE    = R_SHORTS + 3;
	localparam int R_BITMODE = R_SHORTS + 4;
	localparam int R_PRESC   = R_SHORTS + 5;
	localparam int R_CC      = R_SHORTS + 6;
	localparam int R_POWER   = R_CC + CHANNELS;
	localparam int NREGS     = R_POWER + 1;

	// bit positions inside shorts and the interrupt enable mask
	localparam int SHORT_STOP_OFS = 8;
	localparam int IRQ_OFS        = 16;

	// command codes
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// bit mode codes, anything else is 32 bits
	localparam logic [31:0] BITMODE_16 = 32'd0;
	localparam logic [31:0] BITMODE_8  = 32'd1;
	localparam logic [31:0] BITMODE_24 = 32'd2;

	localparam int PRESC_W = (PRESCALE_MAX > 0) ? $clog2(PRESCALE_MAX + 1) : 1;
	localparam int PCNT_W  = (PRESCALE_MAX > 0) ? PRESCALE_MAX : 1;

	typedef logic [CHANNELS-1:0][31:0] word_arr_t;

	// outcome of one timer step's compare pass
	typedef struct packed {
		logic [CHANNELS-1:0] cmp_set;
		logic [CHANNELS-1:0] skip_clr;
		logic                notify;
		logic                clear_now;
		logic                stop_hit;
		logic                irq_set;
	} step_t;

	// one result word
	typedef struct packed {
		logic [31:0] read_value;
		logic        irq_pulse;
		logic        compare_notify;
		logic        status;
	} rsp_t;

endpackage

>>> hdl/cct_cmd_if.sv
// command channel of the compare/capture timer: valid/ready plus one command word
// no dependencies
interface cct_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [4:0]  reg_index;
	logic [31:0] write_value;

	modport source (output valid, output mode, output reg_index, output write_value,
		input ready);
	modport sink (input valid, input mode, input reg_index, input write_value,
		output ready);
endinterface

>>> hdl/cct_rsp_if.sv
// response channel of the compare/capture timer: valid/ready plus one result word
// no dependencies
interface cct_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_value;
	logic        irq_pulse;
	logic        compare_notify;
	logic        status;

	modport source (output valid, output read_value, output irq_pulse,
		output compare_notify, output status, input ready);
	modport sink (input valid, input read_value, input irq_pulse,
		input compare_notify, input status, output ready);
endinterface

>>> hdl/cct_cmp.sv
// compare pass of one timer step over all channels, stop short ends the pass
// depends on cct_pkg
module cct_cmp (
	input  logic [31:0]                  counter,
	input  cct_pkg::word_arr_t           cc,
	input  logic [cct_pkg::CHANNELS-1:0] skip,
	input  logic [31:0]                  shorts,
	input  logic [31:0]                  irq_mask,
	output cct_pkg::step_t               step
);

	always_comb begin
		logic halted;
		halted = 1'b0;
		step   = '0;
		for (int i = 0; i < cct_pkg::CHANNELS; i++) begin
			if (!halted) begin
				if (cc[i] == counter && !skip[i]) begin
					step.cmp_set[i] = 1'b1;
					step.notify     = 1'b1;
					if (shorts[i])
						step.clear_now = 1'b1;
					if (shorts[cct_pkg::SHORT_STOP_OFS + i]) begin
						step.stop_hit = 1'b1;
						halted        = 1'b1;
					end else if (irq_mask[cct_pkg::IRQ_OFS + i]) begin
						step.irq_set = 1'b1;
					end
				end
				// skip flag of the stopping channel is kept
				if (!halted)
					step.skip_clr[i] = 1'b1;
			end
		end
	end

endmodule

>>> hdl/compare_capture_timer_core.sv
// top level of the compare/capture timer: register file, tick logic, result queue
// depends on cct_pkg, cct_cmd_if, cct_rsp_if and cct_cmp
//
// The timer takes one command word per clock: a register read, a register write
// or one base clock tick. Each word is finished in the cycle it is accepted, its
// register and counter update landing at that edge, so words may follow each
// other in every cycle with no gap. Results leave in order through a two-entry
// result queue; a new command is taken whenever fewer than two results wait, so
// a stalled response side holds off commands only after two words have piled up.
// While running, one timer step (compare of all channels, interrupt pulse,
// counter increment with bit-mode wrap) happens every 2^PRESCALER ticks.
module compare_capture_timer_core (
	input  logic       clk,
	input  logic       arst_n,
	cct_cmd_if.sink    cmd,
	cct_rsp_if.source  rsp
);

	localparam int CH = cct_pkg::CHANNELS;

	// architectural state
	logic [31:0]                 counter_q;
	logic                        running_q;
	logic [31:0]                 irq_mask_q;
	logic                        irq_pend_q;
	logic [CH-1:0]               skip_q;
	logic [cct_pkg::PCNT_W-1:0]  pcnt_q;
	logic [31:0]                 start_q, stop_q, clear_q, shorts_q, bitmode_q, power_q;
	logic [cct_pkg::PRESC_W-1:0] presc_q;
	cct_pkg::word_arr_t          capt_q, cmp_q, cc_q;

	// next state
	logic [31:0]                 counter_d;
	logic                        running_d;
	logic [31:0]                 irq_mask_d;
	logic                        irq_pend_d;
	logic [CH-1:0]               skip_d;
	logic [cct_pkg::PCNT_W-1:0]  pcnt_d;
	logic [31:0]                 start_d, stop_d, clear_d, shorts_d, bitmode_d, power_d;
	logic [cct_pkg::PRESC_W-1:0] presc_d;
	cct_pkg::word_arr_t          capt_d, cmp_d, cc_d;

	// result queue
	cct_pkg::rsp_t buf_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    fill_q;

	cct_pkg::rsp_t  res;
	cct_pkg::step_t step;
	logic           accept, pop;
	logic [31:0]    cnt_inc;
	logic [cct_pkg::PCNT_W-1:0] pmask;

	assign accept    = cmd.valid && cmd.ready;
	assign pop       = rsp.valid && rsp.ready;
	assign cmd.ready = (fill_q != 2'd2);

	// compare pass runs on the current counter; used only on a step tick
	cct_cmp u_cmp (
		.counter  (counter_q),
		.cc       (cc_q),
		.skip     (skip_q),
		.shorts   (shorts_q),
		.irq_mask (irq_mask_q),
		.step     (step)
	);

	// counter increment with bit-mode wrap, other codes keep all 32 bits
	always_comb begin
		cnt_inc = counter_q + 32'd1;
		unique case (bitmode_q)
			cct_pkg::BITMODE_16: cnt_inc = cnt_inc & 32'h0000_FFFF;
			cct_pkg::BITMODE_8:  cnt_inc = cnt_inc & 32'h0000_00FF;
			cct_pkg::BITMODE_24: cnt_inc = cnt_inc & 32'h00FF_FFFF;
			default:             cnt_inc = cnt_inc;
		endcase
	end

	// prescale period mask, all ones at the largest prescaler
	assign pmask = (cct_pkg::PCNT_W'(1) << presc_q) - cct_pkg::PCNT_W'(1);

	always_comb begin
		logic [31:0] v;
		int          idx;
		logic        pend;
		logic        run_after;
		v   = cmd.write_value;
		idx = int'(cmd.reg_index);

		counter_d  = counter_q;
		running_d  = running_q;
		irq_mask_d = irq_mask_q;
		irq_pend_d = irq_pend_q;
		skip_d     = skip_q;
		pcnt_d     = pcnt_q;
		start_d    = start_q;
		stop_d     = stop_q;
		clear_d    = clear_q;
		shorts_d   = shorts_q;
		bitmode_d  = bitmode_q;
		power_d    = power_q;
		presc_d    = presc_q;
		capt_d     = capt_q;
		cmp_d      = cmp_q;
		cc_d       = cc_q;
		res        = '0;
		pend       = 1'b0;
		run_after  = 1'b0;

		if (accept) begin
			unique case (cmd.mode)
				cct_pkg::MODE_READ: begin
					if (idx >= cct_pkg::NREGS)
						res.status = 1'b1;
					// exclusive index matches, count and mode always read zero
					if (idx == cct_pkg::R_START)   res.read_value |= start_q;
					if (idx == cct_pkg::R_STOP)    res.read_value |= stop_q;
					if (idx == cct_pkg::R_CLEAR)   res.read_value |= clear_q;
					if (idx == cct_pkg::R_SHORTS)  res.read_value |= shorts_q;
					if (idx == cct_pkg::R_INTSET)  res.read_value |= irq_mask_q;
					if (idx == cct_pkg::R_INTCLR)  res.read_value |= irq_mask_q;
					if (idx == cct_pkg::R_BITMODE) res.read_value |= bitmode_q;
					if (idx == cct_pkg::R_PRESC)   res.read_value |= 32'(presc_q);
					if (idx == cct_pkg::R_POWER)   res.read_value |= power_q;
					for (int i = 0; i < CH; i++) begin
						if (idx == cct_pkg::R_CAPT + i) res.read_value |= capt_q[i];
						if (idx == cct_pkg::R_CMP + i)  res.read_value |= cmp_q[i];
						if (idx == cct_pkg::R_CC + i)   res.read_value |= cc_q[i];
					end
				end
				cct_pkg::MODE_WRITE: begin
					if (idx >= cct_pkg::NREGS || idx == cct_pkg::R_COUNT)
						res.status = 1'b1;
					if (idx == cct_pkg::R_START) begin
						if (v == 32'd0 || running_q) begin
							res.status = 1'b1;
						end else begin
							start_d   = v;
							running_d = 1'b1;
							stop_d    = 32'd0;
						end
					end
					if (idx == cct_pkg::R_STOP) begin
						if (v == 32'd0 || !running_q) begin
							res.status = 1'b1;
						end else begin
							stop_d    = v;
							running_d = 1'b0;
							start_d   = 32'd0;
						end
					end
					if (idx == cct_pkg::R_POWER) begin
						power_d = v;
						// power off stops and resets the count
						if (v == 32'd0) begin
							running_d = 1'b0;
							stop_d    = 32'd1;
							start_d   = 32'd0;
							counter_d = 32'd0;
							pcnt_d    = '0;
						end
					end
					if (idx == cct_pkg::R_MODE && v != 32'd0)
						res.status = 1'b1;
					if (idx == cct_pkg::R_PRESC) begin
						if (v > 32'(cct_pkg::PRESCALE_MAX))
							res.status = 1'b1;
						else
							presc_d = v[cct_pkg::PRESC_W-1:0];
					end
					if (idx == cct_pkg::R_CLEAR) begin
						clear_d   = v;
						counter_d = 32'd0;
					end
					if (idx == cct_pkg::R_SHORTS)  shorts_d   = v;
					if (idx == cct_pkg::R_INTSET)  irq_mask_d = irq_mask_q | v;
					if (idx == cct_pkg::R_INTCLR)  irq_mask_d = irq_mask_q & ~v;
					if (idx == cct_pkg::R_BITMODE) bitmode_d  = v;
					for (int i = 0; i < CH; i++) begin
						if (idx == cct_pkg::R_CAPT + i) begin
							capt_d[i] = v;
							skip_d[i] = 1'b1;
							cc_d[i]   = counter_q;
						end
						if (idx == cct_pkg::R_CMP + i) begin
							cmp_d[i]           = v;
							res.compare_notify = 1'b1;
						end
						if (idx == cct_pkg::R_CC + i)
							cc_d[i] = v;
					end
				end
				cct_pkg::MODE_TICK: begin
					if (!running_q) begin
						pcnt_d = '0;
					end else begin
						run_after = 1'b1;
						if (pcnt_q == '0) begin
							for (int i = 0; i < CH; i++) begin
								if (step.cmp_set[i])  cmp_d[i]  = 32'd1;
								if (step.skip_clr[i]) skip_d[i] = 1'b0;
							end
							res.compare_notify = step.notify;
							pend = irq_pend_q | step.irq_set;
							if (step.stop_hit) begin
								// stop short: no pulse, no increment
								stop_d     = 32'd1;
								start_d    = 32'd0;
								running_d  = 1'b0;
								irq_pend_d = pend;
								run_after  = 1'b0;
							end else begin
								res.irq_pulse = pend;
								irq_pend_d    = 1'b0;
								counter_d     = step.clear_now ? 32'd0 : cnt_inc;
							end
						end
						pcnt_d = run_after ? ((pcnt_q + cct_pkg::PCNT_W'(1)) & pmask) : '0;
					end
				end
				default: res.status = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q  <= 32'd0;
			running_q  <= 1'b0;
			irq_mask_q <= 32'd0;
			irq_pend_q <= 1'b0;
			skip_q     <= '0;
			pcnt_q     <= '0;
			start_q    <= 32'd0;
			stop_q     <= 32'd1;
			clear_q    <= 32'd0;
			shorts_q   <= 32'd0;
			bitmode_q  <= 32'd0;
			power_q    <= 32'd0;
			presc_q    <= '0;
			capt_q     <= '0;
			cmp_q      <= '0;
			cc_q       <= '0;
		end else begin
			counter_q  <= counter_d;
			running_q  <= running_d;
			irq_mask_q <= irq_mask_d;
			irq_pend_q <= irq_pend_d;
			skip_q     <= skip_d;
			pcnt_q     <= pcnt_d;
			start_q    <= start_d;
			stop_q     <= stop_d;
			clear_q    <= clear_d;
			shorts_q   <= shorts_d;
			bitmode_q  <= bitmode_d;
			power_q    <= power_d;
			presc_q    <= presc_d;
			capt_q     <= capt_d;
			cmp_q      <= cmp_d;
			cc_q       <= cc_d;
		end
	end

	// two-entry result queue, payload needs no reset
	always_ff @(posedge clk) begin
		if (accept)
			buf_q[wr_ptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (accept)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({accept, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign rsp.valid          = (fill_q != 2'd0);
	assign rsp.read_value     = buf_q[rd_ptr_q].read_value;
	assign rsp.irq_pulse      = buf_q[rd_ptr_q].irq_pulse;
	assign rsp.compare_notify = buf_q[rd_ptr_q].compare_notify;
	assign rsp.status         = buf_q[rd_ptr_q].status;

endmodule

>>> hdl/cct_checker.sv
// port-level checks of the compare/capture timer and their bind to the top level
// depends on assert_macros.svh and compare_capture_timer_core
`include "assert_macros.svh"

module cct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] read_value,
	input logic        irq_pulse,
	input logic        compare_notify,
	input logic        status
);

	// whole result word as one vector
	logic [34:0] rsp_word;
	assign rsp_word = {read_value, irq_pulse, compare_notify, status};

	// a stalled result stays offered and unchanged
	`CCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`CCT_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_word))

	// a result appears only after a command word was taken
	`CCT_ASSERT_NOW(a_rsp_cause, $rose(rsp_valid), $past(cmd_valid && cmd_ready))

	// taking a result always frees room for a command
	`CCT_ASSERT_NEXT(a_room_after_pop, rsp_valid && rsp_ready, cmd_ready)

	// pulses come only from ticks, errors never from ticks
	`CCT_ASSERT_NOW(a_irq_no_err, rsp_valid && irq_pulse, !status && read_value == 32'd0)

endmodule

bind compare_capture_timer_core cct_checker u_cct_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.read_value     (rsp.read_value),
	.irq_pulse      (rsp.irq_pulse),
	.compare_notify (rsp.compare_notify),
	.status         (rsp.status)
);
